FILE: hdl/bfac_pkg.sv
package bfac_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int HALF_W  = 32;
  localparam int CFG_W   = 11;
  localparam int COUNT_W = 32;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;

  // serial remainder unit: one key bit per cycle, counter holds 0..KEY_W
  localparam int MOD_CNT_W = 7;

  // operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // filter size after reset
  localparam logic [CFG_W-1:0] FILTER_BITS_RESET = 11'd1000;

  // shift-add-xor mix, one step per cycle
  localparam int MIX_STEPS = 5;
  localparam int MIX_SH0   = 10;
  localparam int MIX_SH1   = 6;
  localparam int MIX_SH2   = 3;
  localparam int MIX_SH3   = 11;
  localparam int MIX_SH4   = 15;

  // second hash operand is key plus this
  localparam logic [KEY_W-1:0] KEY_OFFSET = 64'd3;

endpackage

FILE: hdl/bfac_mod.sv
module bfac_mod #(
  parameter int SW = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SW-1:0]              divisor,
  input  logic [bfac_pkg::KEY_W-1:0] dividend_a,
  input  logic [bfac_pkg::KEY_W-1:0] dividend_b,
  output logic [SW-1:0]              rem_a,
  output logic [SW-1:0]              rem_b,
  output logic [SW-1:0]              rem_ones,
  output logic                       done
);

  logic [bfac_pkg::KEY_W-1:0]     shift_a;
  logic [bfac_pkg::KEY_W-1:0]     shift_b;
  logic [SW-1:0]                  div;
  logic [bfac_pkg::MOD_CNT_W-1:0] cnt;

  // one restoring step: bring in a bit, subtract divisor if it fits
  function automatic logic [SW-1:0] rem_step(input logic [SW-1:0] r, input logic b,
                                             input logic [SW-1:0] d);
    logic [SW:0] ext;
    logic [SW:0] dext;
    ext  = {r, b};
    dext = {1'b0, d};
    if (ext >= dext) begin
      rem_step = SW'(ext - dext);
    end else begin
      rem_step = ext[SW-1:0];
    end
  endfunction

  // control: load, then one bit per cycle from the msb down
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= bfac_pkg::MOD_CNT_W'(bfac_pkg::KEY_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == bfac_pkg::MOD_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // three lanes share the divisor; the third divides the all-ones word
  always_ff @(posedge clk) begin
    if (start) begin
      shift_a  <= dividend_a;
      shift_b  <= dividend_b;
      div      <= divisor;
      rem_a    <= '0;
      rem_b    <= '0;
      rem_ones <= '0;
    end else if (cnt != '0) begin
      shift_a  <= {shift_a[bfac_pkg::KEY_W-2:0], 1'b0};
      shift_b  <= {shift_b[bfac_pkg::KEY_W-2:0], 1'b0};
      rem_a    <= rem_step(rem_a, shift_a[bfac_pkg::KEY_W-1], div);
      rem_b    <= rem_step(rem_b, shift_b[bfac_pkg::KEY_W-1], div);
      rem_ones <= rem_step(rem_ones, 1'b1, div);
    end
  end

endmodule

FILE: hdl/bloom_filter_add_check.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+----------------------------
// in       | input     | in_valid / in_stall  | op, key
// out      | output    | out_valid / out_stall| maybe_present, items_added
// config   | input     | cfg_wr_en            | cfg_wr_data (filter_bits)
//
// one word at a time: the time per word is set by the bit-serial remainder unit
// and by one read-modify-write of the bit memory per probe.
// after reset a clearing pass zeros one memory word a cycle and takes no word;
// a finished result waits in the output register while the next word is taken,
// and only the end of that word waits on out_stall.
module bloom_filter_add_check #(
  parameter int MAX_BITS   = 1024,
  parameter int NUM_HASHES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [bfac_pkg::KEY_W-1:0]   key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         maybe_present,
  output logic [bfac_pkg::COUNT_W-1:0] items_added,
  input  logic                         cfg_wr_en,
  input  logic [bfac_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int SW = $clog2(MAX_BITS + 1);
  localparam int CW = (SW > bfac_pkg::CFG_W) ? SW : bfac_pkg::CFG_W;
  localparam int WC = (MAX_BITS + bfac_pkg::WORD_W - 1) / bfac_pkg::WORD_W;
  localparam int AW = (WC > 1) ? $clog2(WC) : 1;
  localparam int JW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_HASH    = 9'b000000100,
    S_MOD_GO  = 9'b000001000,
    S_MOD_RUN = 9'b000010000,
    S_FIX     = 9'b000100000,
    S_RD      = 9'b001000000,
    S_WAIT    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [bfac_pkg::CFG_W-1:0]   filter_bits;
  logic [SW-1:0]                used_size;
  logic [CW-1:0]                fb_ext;

  logic                         op_r;
  logic [bfac_pkg::KEY_W-1:0]   key_a;
  logic [bfac_pkg::KEY_W-1:0]   key_b;
  logic [bfac_pkg::KEY_W-1:0]   mix;
  logic [bfac_pkg::KEY_W-1:0]   mix_next;
  logic [bfac_pkg::KEY_W-1:0]   pp;
  logic [bfac_pkg::KEY_W-1:0]   prod;
  logic [bfac_pkg::HALF_W-1:0]  mul_a;
  logic [bfac_pkg::HALF_W-1:0]  mul_b;
  logic [bfac_pkg::KEY_W-1:0]   mul_out;
  logic [2:0]                   step;

  logic                         mod_start;
  logic                         mod_done;
  logic [SW-1:0]                rem_h1;
  logic [SW-1:0]                rem_prod;
  logic [SW-1:0]                rem_ones;

  logic [SW-1:0]                h2;
  logic [SW-1:0]                wrap_rem;
  logic [SW:0]                  wrap_inc;
  logic [SW-1:0]                idx_r;
  logic [SW-1:0]                idx_next;
  logic [SW:0]                  sum1;
  logic [SW:0]                  red1;
  logic [SW:0]                  red2;
  logic [bfac_pkg::KEY_W:0]     vsum;
  logic [bfac_pkg::KEY_W-1:0]   v;
  logic [JW-1:0]                j;
  logic                         present;

  logic [bfac_pkg::COUNT_W-1:0] add_counter;
  logic [bfac_pkg::COUNT_W-1:0] add_counter_next;

  logic [bfac_pkg::WORD_W-1:0]  mem [WC];
  logic [bfac_pkg::WORD_W-1:0]  rd_data;
  logic [bfac_pkg::WORD_W-1:0]  wr_data;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                word_addr;
  logic [AW-1:0]                clr_addr;
  logic                         mem_we;
  logic                         mem_rd;
  logic                         bit_hit;

  // size in use: zero reads as one, clamp to the store
  always_comb begin
    fb_ext = CW'(filter_bits);
    priority if (fb_ext == '0) begin
      used_size = SW'(1);
    end else if (fb_ext > CW'(MAX_BITS)) begin
      used_size = SW'(MAX_BITS);
    end else begin
      used_size = SW'(fb_ext);
    end
  end

  // one mix step per cycle
  always_comb begin
    unique case (step)
      3'd0:    mix_next = mix + (mix << bfac_pkg::MIX_SH0);
      3'd1:    mix_next = mix ^ (mix >> bfac_pkg::MIX_SH1);
      3'd2:    mix_next = mix + (mix << bfac_pkg::MIX_SH2);
      3'd3:    mix_next = mix ^ (mix >> bfac_pkg::MIX_SH3);
      3'd4:    mix_next = mix + (mix << bfac_pkg::MIX_SH4);
      default: mix_next = mix;
    endcase
  end

  // shared 32x32 multiplier for the low half of key*(key+3)
  always_comb begin
    unique case (step)
      3'd0: begin
        mul_a = key_a[bfac_pkg::HALF_W-1:0];
        mul_b = key_b[bfac_pkg::HALF_W-1:0];
      end
      3'd1: begin
        mul_a = key_a[bfac_pkg::HALF_W-1:0];
        mul_b = key_b[bfac_pkg::KEY_W-1:bfac_pkg::HALF_W];
      end
      default: begin
        mul_a = key_a[bfac_pkg::KEY_W-1:bfac_pkg::HALF_W];
        mul_b = key_b[bfac_pkg::HALF_W-1:0];
      end
    endcase
    mul_out = {{bfac_pkg::HALF_W{1'b0}}, mul_a} * {{bfac_pkg::HALF_W{1'b0}}, mul_b};
  end

  // next probe index: add h2 mod size, take out 2^64 mod size on a wrap
  always_comb begin
    sum1 = {1'b0, idx_r} + {1'b0, h2};
    red1 = (sum1 >= {1'b0, used_size}) ? (sum1 - {1'b0, used_size}) : sum1;
    vsum = {1'b0, v} + (bfac_pkg::KEY_W + 1)'(h2);
    if (vsum[bfac_pkg::KEY_W]) begin
      if (red1 < {1'b0, wrap_rem}) begin
        red2 = red1 + {1'b0, used_size} - {1'b0, wrap_rem};
      end else begin
        red2 = red1 - {1'b0, wrap_rem};
      end
    end else begin
      red2 = red1;
    end
    idx_next = red2[SW-1:0];
    wrap_inc = {1'b0, rem_ones} + (SW + 1)'(1);
  end

  // memory access
  assign word_addr = AW'(idx_r >> bfac_pkg::BIT_W);
  assign mem_rd    = (state == S_RD);
  assign mem_we    = (state == S_CLEAR) || ((state == S_WAIT) && (op_r == bfac_pkg::OP_ADD));
  assign wr_addr   = (state == S_CLEAR) ? clr_addr : word_addr;
  assign wr_data   = (state == S_CLEAR) ? '0
                   : (rd_data | (bfac_pkg::WORD_W'(1) << idx_r[bfac_pkg::BIT_W-1:0]));
  assign bit_hit   = rd_data[idx_r[bfac_pkg::BIT_W-1:0]];

  // bit store; probes run one at a time, so a read never overlaps the write before it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_rd) begin
      rd_data <= mem[word_addr];
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign mod_start = (state == S_MOD_GO);

  assign add_counter_next = ((op_r == bfac_pkg::OP_ADD) && (add_counter != '1))
                          ? add_counter + 1'b1 : add_counter;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_addr == AW'(WC - 1)) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_HASH;
      S_HASH:    if (step == 3'(bfac_pkg::MIX_STEPS - 1)) state_next = S_MOD_GO;
      S_MOD_GO:  state_next = S_MOD_RUN;
      S_MOD_RUN: if (mod_done) state_next = S_FIX;
      S_FIX:     state_next = S_RD;
      S_RD:      state_next = S_WAIT;
      S_WAIT:    state_next = (j == JW'(NUM_HASHES - 1)) ? S_DONE : S_RD;
      S_DONE:    if (!out_valid || !out_stall) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      filter_bits <= bfac_pkg::FILTER_BITS_RESET;
      add_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr_en) begin
        filter_bits <= cfg_wr_data;
      end
      // output register: load a finished word, else drop a taken one
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid   <= 1'b1;
        add_counter <= add_counter_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_r  <= op;
        key_a <= key;
        key_b <= key + bfac_pkg::KEY_OFFSET;
        mix   <= key;
        step  <= '0;
      end
      S_HASH: begin
        mix  <= mix_next;
        step <= step + 1'b1;
        pp   <= mul_out;
        if (step == 3'd1) begin
          prod <= pp;
        end else if ((step == 3'd2) || (step == 3'd3)) begin
          prod[bfac_pkg::KEY_W-1:bfac_pkg::HALF_W] <=
            prod[bfac_pkg::KEY_W-1:bfac_pkg::HALF_W] + pp[bfac_pkg::HALF_W-1:0];
        end
      end
      S_FIX: begin
        idx_r    <= rem_h1;
        h2       <= rem_prod;
        v        <= mix;
        wrap_rem <= (wrap_inc == {1'b0, used_size}) ? '0 : wrap_inc[SW-1:0];
        j        <= '0;
        present  <= 1'b1;
      end
      S_WAIT: begin
        if (!bit_hit) begin
          present <= 1'b0;
        end
        idx_r <= idx_next;
        v     <= vsum[bfac_pkg::KEY_W-1:0];
        j     <= j + 1'b1;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          maybe_present <= (op_r == bfac_pkg::OP_CHECK) && present;
          items_added   <= add_counter_next;
        end
      end
      default: begin
      end
    endcase
  end

  // remainders of h1, the product and the all-ones word by the size
  bfac_mod #(
    .SW(SW)
  ) u_mod (
    .clk        (clk),
    .rst        (rst),
    .start      (mod_start),
    .divisor    (used_size),
    .dividend_a (mix),
    .dividend_b (prod),
    .rem_a      (rem_h1),
    .rem_b      (rem_prod),
    .rem_ones   (rem_ones),
    .done       (mod_done)
  );

  // check never writes the store
  a_check_no_write: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WAIT) && (op_r == bfac_pkg::OP_CHECK)) |-> !mem_we)
    else $error("check operation wrote the bit store");

  // every probe stays inside the size in use
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (idx_r < used_size))
    else $error("probe index not below filter size");

  // insert count never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (add_counter >= $past(add_counter)))
    else $error("insert count decreased");

  // no word taken before the clearing pass ends
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("word accepted during clearing pass");

endmodule

FILE: tb/tb_bloom_filter_add_check.sv
module tb_bloom_filter_add_check;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILTER_MAX  = 1024;
  localparam int PROBES      = 4;
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 200;
  localparam int CYCLE_LIMIT = 900_000;

  typedef struct packed {
    logic                         present;
    logic [bfac_pkg::COUNT_W-1:0] adds;
  } outcome_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         op = bfac_pkg::OP_ADD;
  logic [bfac_pkg::KEY_W-1:0]   key = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         maybe_present;
  logic [bfac_pkg::COUNT_W-1:0] items_added;
  logic                         cfg_wr_en = 1'b0;
  logic [bfac_pkg::CFG_W-1:0]   cfg_wr_data = '0;

  // shadow copy of the filter state
  logic [FILTER_MAX-1:0]        shadow_bits = '0;
  logic [bfac_pkg::COUNT_W-1:0] shadow_adds = '0;
  logic [bfac_pkg::CFG_W-1:0]   shadow_size = bfac_pkg::FILTER_BITS_RESET;

  outcome_t                   pending_results[$];
  logic [bfac_pkg::KEY_W-1:0] inserted_keys[$];
  int                         errors = 0;
  int                         cycle_count;
  bit                         gaps_on = 1'b1;
  bit                         stall_on = 1'b1;
  bit                         hold_req = 1'b0;
  bit                         hold_done = 1'b0;

  bloom_filter_add_check dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .key(key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .maybe_present(maybe_present),
    .items_added(items_added),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // shift-add-xor mix of the key
  function automatic logic [bfac_pkg::KEY_W-1:0] mix_key(logic [bfac_pkg::KEY_W-1:0] x);
    x = x + (x << 10);
    x = x ^ (x >> 6);
    x = x + (x << 3);
    x = x ^ (x >> 11);
    x = x + (x << 15);
    return x;
  endfunction

  // probe the shadow filter for one word, update it and return the result
  function automatic outcome_t filter_step(logic is_check, logic [bfac_pkg::KEY_W-1:0] k);
    logic [bfac_pkg::KEY_W-1:0] modulus;
    logic [bfac_pkg::KEY_W-1:0] h1;
    logic [bfac_pkg::KEY_W-1:0] h2;
    logic [bfac_pkg::KEY_W-1:0] prod;
    logic [bfac_pkg::KEY_W-1:0] pos;
    outcome_t                   res;
    modulus = bfac_pkg::KEY_W'(shadow_size);
    if (modulus == 0) modulus = 1;
    if (modulus > FILTER_MAX) modulus = FILTER_MAX;
    h1 = mix_key(k);
    prod = k * (k + 64'd3);
    h2 = prod % modulus;
    res.present = 1'b1;
    for (int j = 0; j < PROBES; j++) begin
      pos = (h1 + h2 * bfac_pkg::KEY_W'(j)) % modulus;
      if (is_check == bfac_pkg::OP_ADD) shadow_bits[pos] = 1'b1;
      else if (!shadow_bits[pos]) res.present = 1'b0;
    end
    if (is_check == bfac_pkg::OP_ADD) begin
      if (shadow_adds != '1) shadow_adds = shadow_adds + 1'b1;
      res.present = 1'b0;
    end
    res.adds = shadow_adds;
    return res;
  endfunction

  // offer one word and record its expected result once taken
  task automatic offer_word(logic is_check, logic [bfac_pkg::KEY_W-1:0] k);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    op <= is_check;
    key <= k;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(filter_step(is_check, k));
    if (is_check == bfac_pkg::OP_ADD) inserted_keys.push_back(k);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_filter_bits(logic [bfac_pkg::CFG_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_size = value;
  endtask

  function automatic logic [bfac_pkg::KEY_W-1:0] random_key();
    case ($urandom_range(3))
      0: return bfac_pkg::KEY_W'($urandom_range(255));
      1: return ~bfac_pkg::KEY_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // empty filter, key extremes and the size corner cases
  task automatic test_directed();
    offer_word(bfac_pkg::OP_CHECK, 64'd0);
    offer_word(bfac_pkg::OP_ADD, 64'd0);
    offer_word(bfac_pkg::OP_CHECK, 64'd0);
    offer_word(bfac_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(bfac_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_word(bfac_pkg::OP_CHECK, 64'h8000_0000_0000_0000);
    offer_word(bfac_pkg::OP_ADD, 64'd1);
    offer_word(bfac_pkg::OP_CHECK, 64'd1);
    // zero size acts as a single bit
    set_filter_bits(11'd0);
    offer_word(bfac_pkg::OP_ADD, 64'h5555_5555_5555_5555);
    offer_word(bfac_pkg::OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_word(bfac_pkg::OP_CHECK, 64'd0);
    // oversize clamps to the store
    set_filter_bits(11'd2047);
    offer_word(bfac_pkg::OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_word(bfac_pkg::OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_word(bfac_pkg::OP_CHECK, 64'h1234_5678_9ABC_DEF0);
    // resizing keeps the bits already set
    set_filter_bits(11'd1024);
    offer_word(bfac_pkg::OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_word(bfac_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    set_filter_bits(11'd1);
    offer_word(bfac_pkg::OP_CHECK, 64'h0123_4567_89AB_CDEF);
    set_filter_bits(11'd64);
    offer_word(bfac_pkg::OP_ADD, 64'd3);
    offer_word(bfac_pkg::OP_CHECK, 64'd3);
    offer_word(bfac_pkg::OP_CHECK, 64'd4);
    drain();
  endtask

  // adds mixed with checks of known keys, with checks of fresh keys as noise
  task automatic run_mixed_words(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45 || inserted_keys.size() == 0)
        offer_word(bfac_pkg::OP_ADD, random_key());
      else if (pick < 80)
        offer_word(bfac_pkg::OP_CHECK,
                   inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
      else
        offer_word(bfac_pkg::OP_CHECK, random_key());
    end
  endtask

  // random traffic across a spread of filter sizes
  task automatic test_random_sizes();
    logic [bfac_pkg::CFG_W-1:0] sizes[$];
    sizes = '{11'd1024, 11'd2047, 11'd1, 11'd0, 11'd64, 11'd1000};
    repeat (4) sizes.push_back(bfac_pkg::CFG_W'($urandom_range(1024, 1)));
    repeat (2) sizes.push_back(bfac_pkg::CFG_W'($urandom_range(100, 2)));
    foreach (sizes[s]) begin
      set_filter_bits(sizes[s]);
      run_mixed_words(90);
    end
    drain();
  endtask

  // receiver holds off while words keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    run_mixed_words(8);
    while (!hold_done) @(posedge clk);
    hold_req = 1'b0;
    drain();
    gaps_on = 1'b1;
  endtask

  // long stretch at full rate on both sides
  task automatic test_full_rate();
    set_filter_bits(11'd512);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    run_mixed_words(150);
    drain();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    set_filter_bits(bfac_pkg::FILTER_BITS_RESET);
  endtask

  // receiver stall, with one long hold-off on request
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end
      out_stall <= stall_on ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: maybe_present %0d items_added %0d",
                 $time, maybe_present, items_added);
      end else begin
        want = pending_results.pop_front();
        if (maybe_present !== want.present) begin
          errors++;
          $display("%0t maybe_present mismatch: expected %0d actual %0d",
                   $time, want.present, maybe_present);
        end
        if (items_added !== want.adds) begin
          errors++;
          $display("%0t items_added mismatch: expected %0d actual %0d",
                   $time, want.adds, items_added);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_bloom_filter_add_check NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_sizes();
    test_full_rate();
    run_mixed_words(60);
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("tb_bloom_filter_add_check OK");
    else
      $display("tb_bloom_filter_add_check NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hdl/bfac_pkg.sv
hdl/bfac_mod.sv
hdl/bloom_filter_add_check.sv
tb/tb_bloom_filter_add_check.sv
